// ===== rtl/qte_pkg.sv =====
// Shared types, constants and the arctangent table for the quaternion to Euler block.
package qte_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int TABLE_LEN        = 32;
    localparam int NITER            = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS
                                                                     : TABLE_LEN;
    // Lane stages: prepare, six coarse shifts, final doubling, then the rotations.
    localparam int LANE_DEPTH       = 8 + NITER;
    localparam int SQRT_DEPTH       = 33;
    localparam int QDEPTH           = 4;
    localparam int QAW              = $clog2(QDEPTH);

    localparam logic signed [63:0] NORM_LIMIT = 64'sd1 <<< 59;
    localparam logic signed [34:0] ONE_Q30    = 35'sd1 <<< 30;

    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_quat_in;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               pitch_clamped;
    } t_euler_out;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic signed [34:0] roll_num;
        logic signed [34:0] roll_den;
        logic signed [34:0] yaw_num;
        logic signed [34:0] yaw_den;
        logic signed [31:0] sin_arg;
        logic               clamped;
    } t_front_item;

endpackage

// ===== rtl/qte_front.sv =====
// Front end: quaternion products, the atan2 operands and the saturated asin argument.
module qte_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  qte_pkg::t_quat_in    i_quat,
    output logic                 o_valid_a,
    output logic                 o_valid,
    output qte_pkg::t_front_item o_item
);
    import qte_pkg::*;

    logic signed [31:0] r_xx, r_yy, r_zz, r_ww, r_yz, r_wx, r_xy, r_wz, r_zx, r_wy;
    logic               r_va;
    logic               r_vb;
    t_front_item        r_item;
    t_front_item        n_item;
    logic signed [34:0] n_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx <= i_quat.quat_x * i_quat.quat_x;
        r_yy <= i_quat.quat_y * i_quat.quat_y;
        r_zz <= i_quat.quat_z * i_quat.quat_z;
        r_ww <= i_quat.quat_w * i_quat.quat_w;
        r_yz <= i_quat.quat_y * i_quat.quat_z;
        r_wx <= i_quat.quat_w * i_quat.quat_x;
        r_xy <= i_quat.quat_x * i_quat.quat_y;
        r_wz <= i_quat.quat_w * i_quat.quat_z;
        r_zx <= i_quat.quat_z * i_quat.quat_x;
        r_wy <= i_quat.quat_w * i_quat.quat_y;
        r_item <= n_item;
    end

    always_comb begin
        n_item.roll_num = (35'(r_yz) + 35'(r_wx)) <<< 1;
        n_item.roll_den = 35'(r_ww) - 35'(r_xx) - 35'(r_yy) + 35'(r_zz);
        n_item.yaw_num  = (35'(r_xy) + 35'(r_wz)) <<< 1;
        n_item.yaw_den  = 35'(r_ww) + 35'(r_xx) - 35'(r_yy) - 35'(r_zz);
        n_s             = (35'(r_zx) - 35'(r_wy)) <<< 1;
        if (n_s > ONE_Q30) begin
            n_item.sin_arg = 32'(ONE_Q30);
            n_item.clamped = 1'b1;
        end else if (n_s < -ONE_Q30) begin
            n_item.sin_arg = 32'(-ONE_Q30);
            n_item.clamped = 1'b1;
        end else begin
            n_item.sin_arg = n_s[31:0];
            n_item.clamped = 1'b0;
        end
    end

    assign o_valid_a = r_va;
    assign o_valid   = r_vb;
    assign o_item    = r_item;
endmodule

// ===== rtl/qte_fifo.sv =====
// Short queue that decouples the front end from the back end.
module qte_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  qte_pkg::t_front_item i_data,
    output logic                 o_valid,
    output qte_pkg::t_front_item o_data,
    output logic [qte_pkg::QAW:0] o_count
);
    import qte_pkg::*;

    t_front_item      mem [QDEPTH];
    logic [QAW-1:0]   r_wptr, r_rptr;
    logic [QAW:0]     r_count;
    logic             r_valid;
    t_front_item      r_data;
    logic             n_pop;

    assign n_pop = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wptr] <= i_data;
        end
        if (n_pop) begin
            r_data <= mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_pop;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (n_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (QAW+1)'(i_push) - (QAW+1)'(n_pop);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_count = r_count;
endmodule

// ===== rtl/qte_sqrt.sv =====
// Pipelined integer square root of one minus the squared asin argument, one bit per stage.
module qte_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_s,
    output logic               o_valid,
    output logic [63:0]        o_root
);
    import qte_pkg::*;

    logic [63:0] r_n [SQRT_DEPTH];
    logic [63:0] r_r [SQRT_DEPTH];
    logic        r_v [SQRT_DEPTH];
    logic signed [63:0] n_sq;

    // The square reaches 2^60, so the product is formed at full width.
    assign n_sq = i_s * i_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_n[0] <= (64'd1 << 60) - n_sq;
        r_r[0] <= '0;
    end

    for (genvar k = 1; k < SQRT_DEPTH; k++) begin : g_step
        localparam logic [63:0] B = 64'd1 << (62 - 2 * (k - 1));
        logic [63:0] n_t;
        assign n_t = r_r[k-1] + B;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            if (r_n[k-1] >= n_t) begin
                r_n[k] <= r_n[k-1] - n_t;
                r_r[k] <= (r_r[k-1] >> 1) + B;
            end else begin
                r_n[k] <= r_n[k-1];
                r_r[k] <= r_r[k-1] >> 1;
            end
        end
    end

    assign o_valid = r_v[SQRT_DEPTH-1];
    assign o_root  = r_r[SQRT_DEPTH-1];
endmodule

// ===== rtl/qte_cordic.sv =====
// One vectoring CORDIC lane: half-plane fold, normalizing shift and rotation stages.
module qte_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_x,
    output logic               o_valid,
    output logic [31:0]        o_angle
);
    import qte_pkg::*;

    logic signed [63:0] r_x [LANE_DEPTH];
    logic signed [63:0] r_y [LANE_DEPTH];
    logic [31:0]        r_z [LANE_DEPTH];
    logic               r_zero [LANE_DEPTH];
    logic               r_v [LANE_DEPTH];

    // Fold the left half plane onto the right one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_z[0] <= 32'h8000_0000;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    // Coarse shifts by 32, 16, 8, 4, 2, 1 while both operands stay under the limit.
    for (genvar k = 1; k <= 6; k++) begin : g_norm
        localparam int SH = 1 << (6 - k);
        localparam logic signed [63:0] LIM = 64'sd1 <<< (59 - SH);
        logic n_ok;
        assign n_ok = (r_x[k-1] < LIM) && (r_y[k-1] < LIM) && (r_y[k-1] > -LIM);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_zero[k] <= r_zero[k-1];
            r_z[k]    <= r_z[k-1];
            r_x[k]    <= n_ok ? (r_x[k-1] <<< SH) : r_x[k-1];
            r_y[k]    <= n_ok ? (r_y[k-1] <<< SH) : r_y[k-1];
        end
    end

    // The scaling loop doubles once more past the largest shift still under the limit.
    logic n_last_ok;
    assign n_last_ok = (r_x[6] < NORM_LIMIT) && (r_y[6] < NORM_LIMIT)
                       && (r_y[6] > -NORM_LIMIT);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[7] <= 1'b0;
        end else begin
            r_v[7] <= r_v[6];
        end
        r_zero[7] <= r_zero[6];
        r_z[7]    <= r_z[6];
        r_x[7]    <= n_last_ok ? (r_x[6] <<< 1) : r_x[6];
        r_y[7]    <= n_last_ok ? (r_y[6] <<< 1) : r_y[6];
    end

    for (genvar k = 8; k < LANE_DEPTH; k++) begin : g_rot
        localparam int I = k - 8;
        logic signed [63:0] n_dx, n_dy;
        assign n_dx = r_y[k-1] >>> I;
        assign n_dy = r_x[k-1] >>> I;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_zero[k] <= r_zero[k-1];
            if (r_y[k-1] >= 0) begin
                r_x[k] <= r_x[k-1] + n_dx;
                r_y[k] <= r_y[k-1] - n_dy;
                r_z[k] <= r_z[k-1] + ATAN_TAB[I];
            end else begin
                r_x[k] <= r_x[k-1] - n_dx;
                r_y[k] <= r_y[k-1] + n_dy;
                r_z[k] <= r_z[k-1] - ATAN_TAB[I];
            end
        end
    end

    assign o_valid = r_v[LANE_DEPTH-1];
    assign o_angle = r_zero[LANE_DEPTH-1] ? '0 : r_z[LANE_DEPTH-1];
endmodule

// ===== rtl/quaternion_to_euler_zyx.sv =====
// Top level: quaternion to Z-Y-X Euler angles, front end, queue and CORDIC back end.
//
// One quaternion may be transferred in every clock cycle (start high while busy is low),
// and each one yields exactly one result, shown for a single cycle with o_done high,
// in input order. An item passes 2 + 2 + 33 + LANE_DEPTH + 1 register stages, 62 with
// sixteen CORDIC iterations; the first is loaded at the transfer edge and the last holds
// the result and o_done. The figure is set by the 33-stage square root on the pitch path
// and the lane depth of eight plus one stage per iteration. The receiver cannot stall,
// so the back end runs freely and busy only rises if the queue between front and back
// end could overflow, which never happens in steady streaming.
module quaternion_to_euler_zyx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  qte_pkg::t_quat_in   i_quat,
    output logic                o_done,
    output qte_pkg::t_euler_out o_euler
);
    import qte_pkg::*;

    logic             n_accept;
    logic             w_va, w_vb;
    t_front_item      w_front;
    logic             w_qv;
    t_front_item      w_qd;
    logic [QAW:0]     w_qcount;
    logic [QAW+1:0]   n_credit;

    // Count items still in the front end against the queue space.
    assign n_credit = (QAW+2)'(w_qcount) + (QAW+2)'(w_va) + (QAW+2)'(w_vb);
    assign busy     = (n_credit >= (QAW+2)'(QDEPTH));
    assign n_accept = start && !busy;

    qte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (n_accept),
        .i_quat   (i_quat),
        .o_valid_a(w_va),
        .o_valid  (w_vb),
        .o_item   (w_front)
    );

    qte_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_vb),
        .i_data (w_front),
        .o_valid(w_qv),
        .o_data (w_qd),
        .o_count(w_qcount)
    );

    logic        w_sv;
    logic [63:0] w_root;

    qte_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_qv),
        .i_s    (w_qd.sin_arg),
        .o_valid(w_sv),
        .o_root (w_root)
    );

    // The atan2 operands wait alongside the square root.
    t_front_item r_dly [SQRT_DEPTH];
    always_ff @(posedge i_clk) begin
        r_dly[0] <= w_qd;
        for (int k = 1; k < SQRT_DEPTH; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    t_front_item w_al;
    assign w_al = r_dly[SQRT_DEPTH-1];

    logic        w_rv, w_pv, w_yv;
    logic [31:0] w_ra, w_pa, w_ya;

    qte_cordic u_roll (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_sv),
        .i_y    (64'(w_al.roll_num)),
        .i_x    (64'(w_al.roll_den)),
        .o_valid(w_rv),
        .o_angle(w_ra)
    );

    qte_cordic u_pitch (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_sv),
        .i_y    (64'(w_al.sin_arg)),
        .i_x    (w_root),
        .o_valid(w_pv),
        .o_angle(w_pa)
    );

    qte_cordic u_yaw (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_sv),
        .i_y    (64'(w_al.yaw_num)),
        .i_x    (64'(w_al.yaw_den)),
        .o_valid(w_yv),
        .o_angle(w_ya)
    );

    // The saturation flag follows the lanes.
    logic r_clamp [LANE_DEPTH];
    always_ff @(posedge i_clk) begin
        r_clamp[0] <= w_al.clamped;
        for (int k = 1; k < LANE_DEPTH; k++) begin
            r_clamp[k] <= r_clamp[k-1];
        end
    end

    // Rounding: roll and yaw round half up with wrap; the pitch residual is first
    // limited to a quarter turn each way, then negated and rounded half up.
    logic [31:0]        n_rr, n_yr;
    logic signed [31:0] n_pa;
    logic signed [32:0] n_pn;
    t_euler_out         n_out;
    t_euler_out         r_out;
    logic               r_done;

    always_comb begin
        n_rr = w_ra + 32'h0000_8000;
        n_yr = w_ya + 32'h0000_8000;
        n_pa = signed'(w_pa);
        if (n_pa > 32'(ONE_Q30)) begin
            n_pa = 32'(ONE_Q30);
        end else if (n_pa < 32'(-ONE_Q30)) begin
            n_pa = 32'(-ONE_Q30);
        end
        n_pn = -33'(n_pa) + 33'sh8000;
        n_out.roll_angle    = n_rr[31:16];
        n_out.yaw_angle     = n_yr[31:16];
        n_out.pitch_angle   = n_pn[31:16];
        n_out.pitch_clamped = r_clamp[LANE_DEPTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_rv && w_pv && w_yv;
        end
        r_out <= n_out;
    end

    assign o_done  = r_done;
    assign o_euler = r_out;
endmodule
